// ----- rtl/nds_pkg.sv -----
// Shared types and constants for the nonlinear diffusion stencil block.
// No dependencies; imported by the control, datapath and top-level modules.

package nds_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 16;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_BITS     = 16;
    localparam int STEP_BITS       = 16;

    // step is Q4.12 and the stencil carries a factor of one half
    localparam int STEP_FRAC = 13;

    // smallest image dimension the stencil works with
    localparam int MIN_DIM = 3;

    localparam logic [WIDTH_REG_BITS-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0]    RST_IMAGE_HEIGHT = 16'd480;
    localparam logic [STEP_BITS-1:0]      RST_STEP_SIZE    = 16'd1024;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_STEP_SIZE    = 2'd2
    } t_cfg_reg;

    // per-pixel control from the cursor logic to the datapath
    typedef struct packed {
        logic emit;
        logic left;
        logic right;
        logic up;
        logic down;
        logic last;
    } t_emit_info;

endpackage

// ----- rtl/nds_ram.sv -----
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.

module nds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2050,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/nds_ctrl.sv -----
// Configuration registers, ring write pointer and output cursor of the stencil.
// Uses nds_pkg; decides per accepted beat whether a result is due.

module nds_ctrl #(
    parameter int MAX_WIDTH = nds_pkg::DEF_MAX_WIDTH,
    localparam int AW = $clog2(2 * MAX_WIDTH + 2)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [nds_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [nds_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                             i_accept,
    input  logic                             i_drain,
    output nds_pkg::t_emit_info              o_info,
    output logic [AW-1:0]                    o_wr_slot,
    output logic [AW-1:0]                    o_rd_up,
    output logic [AW-1:0]                    o_rd_cen,
    output logic [AW-1:0]                    o_rd_rgt,
    output logic [AW-1:0]                    o_rd_dn,
    output logic [nds_pkg::STEP_BITS-1:0]    o_step
);

    import nds_pkg::*;

    localparam int DEPTH = 2 * MAX_WIDTH + 2;
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int PCB   = $clog2(MAX_WIDTH + 2);
    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int CW    = ((AW > WIDTH_REG_BITS) ? AW : WIDTH_REG_BITS) + 1;
    localparam int RW    = HEIGHT_BITS + 1;

    logic [WIDTH_REG_BITS-1:0] r_image_width;
    logic [HEIGHT_BITS-1:0]    r_image_height;
    logic [STEP_BITS-1:0]      r_step;
    logic [AW-1:0]             r_wr_slot, n_wr_slot;
    logic [AW-1:0]             r_rd_slot, n_rd_slot;
    logic [PCB-1:0]            r_pending, n_pending;
    logic [CB-1:0]             r_out_col, n_out_col;
    logic [HEIGHT_BITS-1:0]    r_out_row, n_out_row;

    logic [WB-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [CW-1:0]          wx, qx, up_x, dn_x;
    logic                   pend_full, end_row, last_row, emit;
    logic                   emit_go, wr_go;
    logic [AW-1:0]          rgt_slot, wr_next;

    always_comb begin
        if (CW'(r_image_width) < CW'(MIN_DIM)) begin
            w_eff = WB'(MIN_DIM);
        end else if (CW'(r_image_width) > CW'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(r_image_width);
        end
    end

    assign h_eff = (r_image_height < HEIGHT_BITS'(MIN_DIM)) ? HEIGHT_BITS'(MIN_DIM)
                                                            : r_image_height;

    assign wx = CW'(w_eff);
    assign qx = CW'(r_rd_slot);

    // bottom neighbour has arrived once a full row plus one is buffered
    assign pend_full = CW'(r_pending) >= wx + CW'(1);
    assign end_row   = CW'(r_out_col) + CW'(1) >= wx;
    assign last_row  = RW'(r_out_row) + RW'(1) >= RW'(h_eff);

    // a drain beat flushes the last row once the right neighbour is in, or at the row end
    assign emit = pend_full ||
                  (i_drain && (r_pending != '0) && last_row &&
                   (end_row || (r_pending >= PCB'(2))));

    assign emit_go = i_accept && emit;
    assign wr_go   = i_accept && !i_drain;

    // ring address arithmetic, all modulo DEPTH
    assign up_x = (qx >= wx) ? (qx - wx) : (qx + CW'(DEPTH) - wx);

    always_comb begin
        dn_x = qx + wx;
        if (dn_x >= CW'(DEPTH)) begin
            dn_x = dn_x - CW'(DEPTH);
        end
    end

    assign rgt_slot = (r_rd_slot == AW'(DEPTH - 1)) ? '0 : r_rd_slot + AW'(1);
    assign wr_next  = (r_wr_slot == AW'(DEPTH - 1)) ? '0 : r_wr_slot + AW'(1);

    always_comb begin
        n_wr_slot = wr_go ? wr_next : r_wr_slot;
        n_rd_slot = emit_go ? rgt_slot : r_rd_slot;

        case ({emit_go, wr_go})
            2'b10:   n_pending = r_pending - PCB'(1);
            2'b01:   n_pending = r_pending + PCB'(1);
            default: n_pending = r_pending;
        endcase

        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit_go) begin
            if (end_row) begin
                n_out_col = '0;
                n_out_row = last_row ? '0 : r_out_row + HEIGHT_BITS'(1);
            end else begin
                n_out_col = r_out_col + CB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_step         <= RST_STEP_SIZE;
            r_wr_slot      <= '0;
            r_rd_slot      <= '0;
            r_pending      <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_REG_BITS-1:0];
                    CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HEIGHT_BITS-1:0];
                    CFG_STEP_SIZE:    r_step         <= i_cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            r_wr_slot <= n_wr_slot;
            r_rd_slot <= n_rd_slot;
            r_pending <= n_pending;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    assign o_info = '{
        emit:  emit,
        left:  (r_out_col != '0),
        right: !end_row,
        up:    (r_out_row != '0),
        down:  !last_row,
        last:  last_row && end_row
    };

    assign o_wr_slot = r_wr_slot;
    assign o_rd_up   = AW'(up_x);
    assign o_rd_cen  = r_rd_slot;
    assign o_rd_rgt  = rgt_slot;
    assign o_rd_dn   = AW'(dn_x);
    assign o_step    = r_step;

endmodule

// ----- rtl/nds_flux_pipe.sv -----
// Arithmetic pipeline: neighbour fluxes, sum, step scaling, rounding, clamp.
// Uses nds_pkg; five register stages moved by one common advance enable.

module nds_flux_pipe #(
    parameter int PIXEL_BITS = nds_pkg::DEF_PIXEL_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  nds_pkg::t_emit_info           i_info,
    input  logic [nds_pkg::STEP_BITS-1:0] i_step,
    input  logic [2*PIXEL_BITS-1:0]       i_cen,
    input  logic [2*PIXEL_BITS-1:0]       i_lft,
    input  logic [2*PIXEL_BITS-1:0]       i_rgt,
    input  logic [2*PIXEL_BITS-1:0]       i_up,
    input  logic [2*PIXEL_BITS-1:0]       i_dn,
    output logic                          o_valid,
    output logic [PIXEL_BITS-1:0]         o_new_level,
    output logic                          o_frame_last
);

    import nds_pkg::*;

    localparam int PB   = PIXEL_BITS;
    localparam int TW   = 2 * PB + 2;          // one flux term
    localparam int SW   = 2 * PB + 4;          // sum of four terms
    localparam int MW   = 2 * PB + 3;          // magnitude of the sum
    localparam int SH   = STEP_BITS / 2;
    localparam int HW   = MW + SH;
    localparam int PW   = MW + STEP_BITS;
    localparam int RES  = PB + STEP_FRAC;
    localparam int MAGW = PW - RES;
    localparam int VW   = MAGW + 2;

    // packed pixel: conductivity in the upper half, level in the lower
    logic [2*PB-1:0]       nb [4];
    logic                  en [4];
    logic [PB:0]           csum [4];
    logic signed [PB+1:0]  cs_s [4];
    logic signed [PB:0]    df [4];
    logic signed [TW:0]    pr [4];
    logic signed [TW-1:0]  n_term [4];

    logic signed [TW-1:0]  r_b_term [4];
    logic [PB-1:0]         r_b_lvl;
    logic                  r_b_last, r_b_valid;

    logic signed [SW-1:0]  c_sum;
    logic [MW-1:0]         n_c_mag;
    logic [MW-1:0]         r_c_mag;
    logic                  r_c_neg;
    logic [PB-1:0]         r_c_lvl;
    logic                  r_c_last, r_c_valid;

    logic [HW-1:0]         r_d_hi, r_d_lo;
    logic                  r_d_neg;
    logic [PB-1:0]         r_d_lvl;
    logic                  r_d_last, r_d_valid;

    logic [PW-1:0]         e_prod, e_rnd;
    logic [MAGW-1:0]       r_e_mag;
    logic                  r_e_neg;
    logic [PB-1:0]         r_e_lvl;
    logic                  r_e_last, r_e_valid;

    logic [VW-1:0]         v_sum;
    logic [PB-1:0]         n_new_level;
    logic [PB-1:0]         r_o_new_level;
    logic                  r_o_frame_last, r_o_valid;

    assign nb[0] = i_lft;
    assign nb[1] = i_rgt;
    assign nb[2] = i_up;
    assign nb[3] = i_dn;
    assign en[0] = i_info.left;
    assign en[1] = i_info.right;
    assign en[2] = i_info.up;
    assign en[3] = i_info.down;

    // stage B: (C + Cn) * (Ln - L) for each neighbour, zero where absent
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            csum[k]   = (PB + 1)'(i_cen[2*PB-1:PB]) + (PB + 1)'(nb[k][2*PB-1:PB]);
            cs_s[k]   = $signed({1'b0, csum[k]});
            df[k]     = $signed({1'b0, nb[k][PB-1:0]}) - $signed({1'b0, i_cen[PB-1:0]});
            pr[k]     = cs_s[k] * df[k];
            n_term[k] = en[k] ? pr[k][TW-1:0] : '0;
        end
    end

    // stage C: sum and split into sign and magnitude
    assign c_sum = SW'(r_b_term[0]) + SW'(r_b_term[1]) +
                   SW'(r_b_term[2]) + SW'(r_b_term[3]);
    assign n_c_mag = c_sum[SW-1] ? MW'(-c_sum) : MW'(c_sum);

    // stage E: recombine the two partial products, round half away from zero
    assign e_prod = (PW'(r_d_hi) << SH) + PW'(r_d_lo);
    assign e_rnd  = e_prod + (PW'(1) << (RES - 1));

    // output stage: apply the update and saturate
    always_comb begin
        v_sum = r_e_neg ? (VW'(r_e_lvl) - VW'(r_e_mag)) : (VW'(r_e_lvl) + VW'(r_e_mag));
        if (v_sum[VW-1]) begin
            n_new_level = '0;
        end else if (v_sum > VW'({PB{1'b1}})) begin
            n_new_level = {PB{1'b1}};
        end else begin
            n_new_level = v_sum[PB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= i_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_o_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_b_term[k] <= n_term[k];
            end
            r_b_lvl  <= i_cen[PB-1:0];
            r_b_last <= i_info.last;

            r_c_mag  <= n_c_mag;
            r_c_neg  <= c_sum[SW-1];
            r_c_lvl  <= r_b_lvl;
            r_c_last <= r_b_last;

            r_d_hi   <= r_c_mag * i_step[STEP_BITS-1:SH];
            r_d_lo   <= r_c_mag * i_step[SH-1:0];
            r_d_neg  <= r_c_neg;
            r_d_lvl  <= r_c_lvl;
            r_d_last <= r_c_last;

            r_e_mag  <= e_rnd[PW-1:RES];
            r_e_neg  <= r_d_neg;
            r_e_lvl  <= r_d_lvl;
            r_e_last <= r_d_last;

            r_o_new_level  <= n_new_level;
            r_o_frame_last <= r_e_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_new_level  = r_o_new_level;
    assign o_frame_last = r_o_frame_last;

endmodule

// ----- rtl/nonlinear_diffusion_step.sv -----
// Top level of the explicit nonlinear diffusion stencil (5-point, zero flux at edges).
// Uses nds_pkg, nds_ctrl, nds_ram and nds_flux_pipe.
//
//   channel  direction  handshake                 payload
//   pixel    in         i_valid / o_stall         i_level, i_conduct, i_drain
//   result   out        o_valid / i_stall         o_new_level, o_frame_last
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One pixel beat per cycle while o_stall is low. A result passes through the ring read and then
// the five-stage flux, scale, round and clamp pipeline after the beat that releases it.
// Pixel pairs live in a ring of 2*MAX_WIDTH+2 entries, kept in two RAM copies with
// two read ports each, giving the four ring reads a result needs in one cycle.
// Reset is synchronous; it clears cursors and valid bits, not the line RAMs.
// All stages share one advance enable; o_stall is high only while a result beat sits
// at the output under i_stall.

module nonlinear_diffusion_step #(
    parameter int MAX_WIDTH  = nds_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = nds_pkg::DEF_PIXEL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [PIXEL_BITS-1:0]             i_level,
    input  logic [PIXEL_BITS-1:0]             i_conduct,
    input  logic                              i_drain,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [PIXEL_BITS-1:0]             o_new_level,
    output logic                              o_frame_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nds_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [nds_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    import nds_pkg::*;

    localparam int DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = 2 * PIXEL_BITS;

    logic                 w_adv, w_acc, w_out_valid;
    t_emit_info           w_info;
    logic [AW-1:0]        w_wr_slot, w_rd_up, w_rd_cen, w_rd_rgt, w_rd_dn;
    logic [STEP_BITS-1:0] w_step;
    logic [XW-1:0]        w_wdata;
    logic                 w_we, w_re;
    logic [XW-1:0]        w_up, w_cen, w_rgt, w_dn;

    logic                 r_a_valid;
    t_emit_info           r_a_info;
    logic [XW-1:0]        r_lft;

    assign w_adv   = !w_out_valid || !i_stall;
    assign o_stall = !w_adv;
    assign w_acc   = i_valid && w_adv;

    assign o_cfg_ready = 1'b1;

    nds_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_acc),
        .i_drain     (i_drain),
        .o_info      (w_info),
        .o_wr_slot   (w_wr_slot),
        .o_rd_up     (w_rd_up),
        .o_rd_cen    (w_rd_cen),
        .o_rd_rgt    (w_rd_rgt),
        .o_rd_dn     (w_rd_dn),
        .o_step      (w_step)
    );

    assign w_wdata = {i_conduct, i_level};
    assign w_we    = w_acc && !i_drain;
    assign w_re    = w_acc && w_info.emit;

    nds_ram #(
        .WIDTH (XW),
        .DEPTH (DEPTH)
    ) u_ring_a (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_wr_slot),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_rd_up),
        .i_raddr_b (w_rd_cen),
        .o_rdata_a (w_up),
        .o_rdata_b (w_cen)
    );

    nds_ram #(
        .WIDTH (XW),
        .DEPTH (DEPTH)
    ) u_ring_b (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_wr_slot),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_rd_rgt),
        .i_raddr_b (w_rd_dn),
        .o_rdata_a (w_rgt),
        .o_rdata_b (w_dn)
    );

    // stage A: ring read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_acc && w_info.emit;
        end
    end

    // results leave in consecutive ring order, so the left neighbour is the
    // previous result's centre
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_info <= w_info;
        end
        if (w_adv && r_a_valid) begin
            r_lft <= w_cen;
        end
    end

    nds_flux_pipe #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_flux (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (r_a_valid),
        .i_info       (r_a_info),
        .i_step       (w_step),
        .i_cen        (w_cen),
        .i_lft        (r_lft),
        .i_rgt        (w_rgt),
        .i_up         (w_up),
        .i_dn         (w_dn),
        .o_valid      (w_out_valid),
        .o_new_level  (o_new_level),
        .o_frame_last (o_frame_last)
    );

    assign o_valid = w_out_valid;

`ifndef SYNTHESIS
    // the pixel written in a cycle never lands on a slot read for a result
    a_no_ring_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_drain && w_info.emit) |->
            ((w_wr_slot != w_rd_up) && (w_wr_slot != w_rd_cen) &&
             (w_wr_slot != w_rd_rgt) && (w_wr_slot != w_rd_dn)))
        else $error("ring write slot collides with a stencil read");

    // cursors hold while the pipeline is frozen
    a_cursor_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(w_rd_cen) && $stable(w_wr_slot)))
        else $error("ring pointers moved during a stall");

    // a result in the read stage is neither lost nor altered by a stall
    a_stage_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !w_adv) |=> (r_a_valid && $stable(r_a_info)))
        else $error("read stage changed during a stall");
`endif

endmodule

// ----- tb/diffusion_checker.sv -----
// Scoreboard for the nonlinear diffusion stencil: watches the pixel, result and register
// channels, predicts each result beat and compares it. Depends on nds_pkg.

module diffusion_checker #(
    parameter int MAX_WIDTH  = nds_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = nds_pkg::DEF_PIXEL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_pix_valid,
    input  logic                              i_pix_stall,
    input  logic [PIXEL_BITS-1:0]             i_level,
    input  logic [PIXEL_BITS-1:0]             i_conduct,
    input  logic                              i_drain,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic [PIXEL_BITS-1:0]             i_new_level,
    input  logic                              i_frame_last,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [nds_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [nds_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                o_fail_count,
    output int                                o_outstanding
);

    import nds_pkg::*;

    localparam int RING_SLOTS = 2 * MAX_WIDTH + 2;
    // step is Q4.12 split into an upper and a lower byte before the final shift
    localparam int ROUND_SHIFT = PIXEL_BITS + STEP_FRAC - 8;
    localparam longint LEVEL_MAX = (longint'(1) << PIXEL_BITS) - 1;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] level;
        logic                  last;
    } t_pixel_out;

    t_pixel_out               want_q[$];
    logic [PIXEL_BITS-1:0]    lines_level [RING_SLOTS];
    logic [PIXEL_BITS-1:0]    lines_cond [RING_SLOTS];
    logic [WIDTH_REG_BITS-1:0] width_reg;
    logic [HEIGHT_BITS-1:0]   height_reg;
    logic [STEP_BITS-1:0]     step_reg;
    int                       wr_slot;
    int                       held;
    int                       out_col;
    int                       out_row;
    int                       errors = 0;
    int                       beats_seen = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", beats_seen, msg);
        errors++;
    endtask

    function automatic longint pair_flux(input int q, input int n);
        longint csum;
        longint diff;
        csum = longint'(lines_cond[q]) + longint'(lines_cond[n]);
        diff = longint'(lines_level[n]) - longint'(lines_level[q]);
        return csum * diff;
    endfunction

    // One accepted pixel beat: maybe release the oldest held pixel, then store the new one unless it is a drain beat.
    task automatic advance_stencil(input logic [PIXEL_BITS-1:0] lvl_in,
                                   input logic [PIXEL_BITS-1:0] cond_in,
                                   input logic drain);
        int w;
        int h;
        int q;
        logic last_row;
        logic end_row;
        logic emit;
        longint sum;
        longint lvl;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        t_pixel_out item;

        w = width_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
        last_row = (out_row + 1 >= h);

        if (held >= w + 1) begin
            emit = 1'b1;
        end else begin
            // bottom row drains once the right neighbour is in, or at the row end
            emit = drain && held >= 1 && last_row && (out_col + 1 >= w || held >= 2);
        end

        if (emit) begin
            q = (wr_slot + RING_SLOTS - held) % RING_SLOTS;
            end_row = (out_col + 1 >= w);
            sum = 0;
            if (out_col > 0)     sum += pair_flux(q, (q + RING_SLOTS - 1) % RING_SLOTS);
            if (out_col + 1 < w) sum += pair_flux(q, (q + 1) % RING_SLOTS);
            if (out_row > 0)     sum += pair_flux(q, (q + RING_SLOTS - w) % RING_SLOTS);
            if (out_row + 1 < h) sum += pair_flux(q, (q + w) % RING_SLOTS);
            mag = (sum < 0) ? -sum : sum;
            hi = mag * step_reg[STEP_BITS-1:8];
            lo = mag * step_reg[7:0];
            // round half away from zero on the magnitude
            mag = (hi + (lo >> 8) + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            lvl = longint'(lines_level[q]) + ((sum < 0) ? -longint'(mag) : longint'(mag));
            if (lvl < 0) lvl = 0;
            if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
            item.level = lvl[PIXEL_BITS-1:0];
            item.last = last_row && end_row;
            want_q.push_back(item);
            held--;
            if (end_row) begin
                out_col = 0;
                out_row = last_row ? 0 : out_row + 1;
            end else begin
                out_col++;
            end
        end

        if (!drain) begin
            lines_level[wr_slot] = lvl_in;
            lines_cond[wr_slot] = cond_in;
            wr_slot = (wr_slot + 1) % RING_SLOTS;
            held++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_out want;
        if (!i_rst_n) begin
            width_reg = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            step_reg = RST_STEP_SIZE;
            wr_slot = 0;
            held = 0;
            out_col = 0;
            out_row = 0;
            want_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg = i_cfg_data[WIDTH_REG_BITS-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg_data[HEIGHT_BITS-1:0];
                    CFG_STEP_SIZE:    step_reg = i_cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_pix_valid && !i_pix_stall) begin
                advance_stencil(i_level, i_conduct, i_drain);
            end
            if (i_res_valid && !i_res_stall) begin
                if (want_q.size() == 0) begin
                    report_mismatch($sformatf("level %0d with no result expected", i_new_level));
                end else begin
                    want = want_q.pop_front();
                    if (i_new_level !== want.level)
                        report_mismatch($sformatf("new_level %0d, expected %0d",
                                                  i_new_level, want.level));
                    if (i_frame_last !== want.last)
                        report_mismatch($sformatf("frame_last %0b, expected %0b",
                                                  i_frame_last, want.last));
                end
                beats_seen++;
            end
        end
        o_fail_count <= errors;
        o_outstanding <= want_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for nonlinear_diffusion_step: clock, reset, pixel and register stimulus,
// random result back-pressure and the verdict. Depends on nds_pkg and diffusion_checker.

module tb_top;
    import nds_pkg::*;

    localparam int PIX         = DEF_PIXEL_BITS;
    localparam int ITEMS       = 1100;
    // pixels kept back for the long-row frame at the end
    localparam int TAIL_PIXELS = 400;
    localparam int IDLE_PCT    = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_PAD   = 12;
    localparam int LIMIT       = 200000;
    localparam logic [PIX-1:0] LEVEL_TOP = '1;
    localparam logic [PIX-1:0] LEVEL_BOT = '0;

    typedef enum int {TEX_NOISE, TEX_EXTREME, TEX_SMOOTH} t_texture;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     pix_valid = 1'b0;
    logic                     pix_stall;
    logic [PIX-1:0]           level = '0;
    logic [PIX-1:0]           conduct = '0;
    logic                     drain = 1'b0;
    logic                     res_valid;
    logic                     res_stall = 1'b0;
    logic [PIX-1:0]           new_level;
    logic                     frame_last;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    int   pixels_sent = 0;
    int   frame_w = 640;
    int   frame_h = 480;
    int   carry = 0;
    logic calm = 1'b0;
    logic hold_go = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    nonlinear_diffusion_step uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (pix_valid),
        .o_stall      (pix_stall),
        .i_level      (level),
        .i_conduct    (conduct),
        .i_drain      (drain),
        .o_valid      (res_valid),
        .i_stall      (res_stall),
        .o_new_level  (new_level),
        .o_frame_last (frame_last),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    diffusion_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_pix_valid   (pix_valid),
        .i_pix_stall   (pix_stall),
        .i_level       (level),
        .i_conduct     (conduct),
        .i_drain       (drain),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_new_level   (new_level),
        .i_frame_last  (frame_last),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("nonlinear_diffusion_step test failed");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off
    always @(posedge clk) begin
        if (hold_left > 0) begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            res_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic [PIX-1:0] pick_sample(input t_texture tex,
                                                   input logic [PIX-1:0] base);
        case (tex)
            TEX_NOISE: return PIX'($urandom);
            TEX_EXTREME: begin
                case ($urandom_range(3))
                    0: return LEVEL_BOT;
                    1: return LEVEL_TOP;
                    default: return PIX'($urandom);
                endcase
            end
            default: return base + PIX'($urandom_range(511)) - PIX'(256);
        endcase
    endfunction

    task automatic send_beat(input logic [PIX-1:0] lvl, input logic [PIX-1:0] cnd,
                             input logic drn);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pix_valid <= 1'b1;
        level <= lvl;
        conduct <= cnd;
        drain <= drn;
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        if (!drn) pixels_sent++;
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                frame_w = val[WIDTH_REG_BITS-1:0];
                if (frame_w < MIN_DIM) frame_w = MIN_DIM;
                if (frame_w > DEF_MAX_WIDTH) frame_w = DEF_MAX_WIDTH;
            end
            CFG_IMAGE_HEIGHT: frame_h = (val < MIN_DIM) ? MIN_DIM : val;
            default: ;
        endcase
    endtask

    task automatic send_frame(input int count, input t_texture tex);
        logic [PIX-1:0] base_l;
        logic [PIX-1:0] base_c;
        base_l = PIX'($urandom);
        base_c = PIX'($urandom);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 4) send_beat(PIX'($urandom), PIX'($urandom), 1'b1);
            send_beat(pick_sample(tex, base_l), pick_sample(tex, base_c), 1'b0);
            base_l += PIX'($urandom_range(64)) - PIX'(32);
        end
    endtask

    // enough drain beats to flush the bottom row, and up to two more that do nothing
    task automatic close_frame();
        int n;
        n = frame_w + 1 + $urandom_range(2);
        repeat (n) send_beat(PIX'($urandom), PIX'($urandom), 1'b1);
    endtask

    task automatic settle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // whole frames back to back, optionally the head of the next one, then flush
    task automatic run_phase(input int frames, input t_texture tex);
        for (int f = 0; f < frames; f++) begin
            send_frame(frame_w * frame_h - carry, tex);
            carry = 0;
        end
        carry = ($urandom_range(2) == 0) ? $urandom_range(1, MIN_DIM) : 0;
        send_frame(carry, tex);
        close_frame();
        settle();
    endtask

    initial begin
        int phase;
        int r;
        logic [CFG_DATA_BITS-1:0] val;
        logic force_h;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 checkerboard at full step: saturates both ways; width and height below minimum
        cfg_write(CFG_IMAGE_WIDTH, 16'd0);
        cfg_write(CFG_IMAGE_HEIGHT, 16'd1);
        cfg_write(CFG_STEP_SIZE, 16'hFFFF);
        for (int i = 0; i < 9; i++) begin
            send_beat(i[0] ? LEVEL_TOP : LEVEL_BOT,
                      (i < 4 || i == 8) ? LEVEL_TOP : LEVEL_BOT, 1'b0);
            // drain with a full row plus one held: releases a result mid-frame
            if (i == 4) send_beat(LEVEL_TOP, LEVEL_BOT, 1'b1);
        end
        close_frame();
        settle();
        cfg_write(CFG_STEP_SIZE, 16'h0000);
        cfg_write(CFG_IMAGE_HEIGHT, 16'd2);
        send_frame(9, TEX_EXTREME);
        close_frame();
        settle();

        phase = 0;
        while (phase < 5 || pixels_sent < ITEMS - TAIL_PIXELS) begin
            force_h = (phase == 0);
            if (phase == 2) calm <= 1'b1;
            if (phase == 4) begin
                calm <= 1'b0;
                // very tall frame: only a few pixels go in, then the height comes back down
                cfg_write(CFG_IMAGE_HEIGHT, 16'hFFFF);
                while (carry < MIN_DIM) begin
                    send_beat(PIX'($urandom), PIX'($urandom), 1'b0);
                    carry++;
                end
                send_beat(PIX'($urandom), PIX'($urandom), 1'b1);
                settle();
                force_h = 1'b1;
            end

            if (phase == 0 || $urandom_range(99) < 70) begin
                r = $urandom_range(99);
                if (r < 55)      val = CFG_DATA_BITS'($urandom_range(3, 8));
                else if (r < 75) val = CFG_DATA_BITS'($urandom_range(9, 24));
                else if (r < 85) val = CFG_DATA_BITS'($urandom_range(0, 2));
                else if (r < 92) val = {5'($urandom), 11'($urandom_range(3, 16))};
                else             val = CFG_DATA_BITS'($urandom_range(25, 64));
                if (phase == 3) val = 16'd8;
                cfg_write(CFG_IMAGE_WIDTH, val);
            end
            if (force_h || phase == 3 || $urandom_range(99) < 70) begin
                r = $urandom_range(99);
                if (r < 70)      val = CFG_DATA_BITS'($urandom_range(3, 6));
                else if (r < 85) val = CFG_DATA_BITS'($urandom_range(0, 2));
                else             val = CFG_DATA_BITS'($urandom_range(7, 16));
                if (phase == 3) val = 16'd8;
                cfg_write(CFG_IMAGE_HEIGHT, val);
            end
            if (phase == 0 || $urandom_range(99) < 70) begin
                r = $urandom_range(99);
                if (r < 50)      val = CFG_DATA_BITS'($urandom);
                else if (r < 65) val = 16'hFFFF;
                else if (r < 75) val = 16'h0000;
                else if (r < 90) val = CFG_DATA_BITS'($urandom_range(0, 4095));
                else             val = 16'h1000;
                cfg_write(CFG_STEP_SIZE, val);
            end

            // receiver holds off while the frame streams in, so the block backs up
            if (phase == 3) hold_go <= 1'b1;
            run_phase((phase == 3) ? 2 : $urandom_range(1, 3),
                      t_texture'($urandom_range(TEX_SMOOTH)));
            phase++;
        end

        // long rows, shortest frame: the ring runs far ahead of the output
        cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_BITS'($urandom_range(96, 128)));
        cfg_write(CFG_IMAGE_HEIGHT, 16'd0);
        cfg_write(CFG_STEP_SIZE, 16'($urandom));
        run_phase(1, TEX_SMOOTH);

        if (fail_count == 0 && outstanding == 0) begin
            $display("nonlinear_diffusion_step test passed");
        end else begin
            $display("nonlinear_diffusion_step test failed");
        end
        $finish;
    end

endmodule
